// ===== rtl/kmq_pkg.sv =====
// kmq_pkg: shared types and codes for the k-means color quantizer
// no dependencies
`timescale 1ns / 1ps
package kmq_pkg;
  localparam int MAX_MEANS    = 16;
  localparam int CHANNEL_BITS = 16;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_ACCUM = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_CLASS = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  mean_index;
    logic [15:0] in_red;
    logic [15:0] in_green;
    logic [15:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  nearest_index;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load_mean;
    logic scan_first;
    logic scan_step;
    logic accum;
    logic div_start;
    logic div_write;
    logic clear_all;
    logic read_mean;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       scan_last;
    logic       div_done;
    logic       div_last;
  } stat_t;
endpackage

// ===== rtl/kmq_datapath.sv =====
// kmq_datapath: mean store, sums, counts, distance unit and serial divider
// depends on kmq_pkg
`timescale 1ns / 1ps
module kmq_datapath #(
  parameter int PIXELS_LOG2  = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kmq_pkg::in_item_t in_item,
  input  logic [4:0]        num_means,
  input  kmq_pkg::cmd_t     cmd,
  output kmq_pkg::stat_t    stat,
  output kmq_pkg::out_item_t res
);
  import kmq_pkg::*;

  localparam int IW = (MAX_MEANS > 1) ? $clog2(MAX_MEANS) : 1;
  localparam int CW = IW + 1;
  localparam int SW = CHANNEL_BITS + PIXELS_LOG2;
  localparam int NW = PIXELS_LOG2 + 1;
  localparam int DW = 2 * CHANNEL_BITS + 2;
  localparam int QW = SW;
  localparam int BW = $clog2(QW + 1);

  logic [3*CHANNEL_BITS-1:0] mean_r [MAX_MEANS];
  logic [SW-1:0] sr_r [MAX_MEANS];
  logic [SW-1:0] sg_r [MAX_MEANS];
  logic [SW-1:0] sb_r [MAX_MEANS];
  logic [NW-1:0] cnt_r [MAX_MEANS];
  logic [MAX_MEANS-1:0] valid_r;

  logic [1:0] func_r;
  logic [3:0] idx_r;
  logic [CHANNEL_BITS-1:0] pr_r, pg_r, pb_r;
  logic [CW-1:0] act_w;
  logic [IW-1:0] ptr_r, best_r;
  logic [DW-1:0] best_d_r;
  logic [3*CHANNEL_BITS-1:0] mcur;
  logic [CHANNEL_BITS-1:0] dr, dg, db;
  logic [DW-1:0] dist_w;

  // divider state: three channels in parallel, one quotient bit a cycle
  logic [SW-1:0] nr_r, ng_r, nb_r;
  logic [NW:0] rr_r, rg_r, rb_r;
  logic [QW-1:0] qr_r, qg_r, qb_r;
  logic [NW-1:0] dv_r;
  logic [BW-1:0] bit_r;
  logic [NW:0] tr, tg, tb;

  out_item_t res_r;

  always_comb begin
    if (num_means == 5'd0) act_w = CW'(1);
    else if (32'(num_means) > MAX_MEANS) act_w = CW'(MAX_MEANS);
    else act_w = CW'(num_means);
  end

  assign mcur = valid_r[ptr_r] ? mean_r[ptr_r] : '0;
  assign dr = (pr_r > mcur[CHANNEL_BITS-1:0]) ? pr_r - mcur[CHANNEL_BITS-1:0]
                                               : mcur[CHANNEL_BITS-1:0] - pr_r;
  assign dg = (pg_r > mcur[2*CHANNEL_BITS-1:CHANNEL_BITS])
            ? pg_r - mcur[2*CHANNEL_BITS-1:CHANNEL_BITS]
            : mcur[2*CHANNEL_BITS-1:CHANNEL_BITS] - pg_r;
  assign db = (pb_r > mcur[3*CHANNEL_BITS-1:2*CHANNEL_BITS])
            ? pb_r - mcur[3*CHANNEL_BITS-1:2*CHANNEL_BITS]
            : mcur[3*CHANNEL_BITS-1:2*CHANNEL_BITS] - pb_r;
  assign dist_w = DW'(dr) * DW'(dr) + DW'(dg) * DW'(dg) + DW'(db) * DW'(db);

  assign tr = {rr_r[NW-1:0], nr_r[SW-1]} - {1'b0, dv_r};
  assign tg = {rg_r[NW-1:0], ng_r[SW-1]} - {1'b0, dv_r};
  assign tb = {rb_r[NW-1:0], nb_r[SW-1]} - {1'b0, dv_r};

  assign stat.func = func_r;
  assign stat.scan_last = (CW'(ptr_r) == act_w - CW'(1));
  assign stat.div_done = (bit_r == '0);
  assign stat.div_last = stat.scan_last;
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < MAX_MEANS; i++) cnt_r[i] <= '0;
      bit_r <= '0;
    end else begin
      if (cmd.capture) begin
        func_r <= in_item.func;
        idx_r <= in_item.mean_index;
        pr_r <= in_item.in_red[CHANNEL_BITS-1:0];
        pg_r <= in_item.in_green[CHANNEL_BITS-1:0];
        pb_r <= in_item.in_blue[CHANNEL_BITS-1:0];
        ptr_r <= '0;
        res_r <= '0;
      end
      if (cmd.load_mean && 32'(idx_r) < MAX_MEANS) begin
        mean_r[idx_r[IW-1:0]] <= {pb_r, pg_r, pr_r};
        valid_r[idx_r[IW-1:0]] <= 1'b1;
      end
      if (cmd.scan_first || cmd.scan_step) begin
        if (cmd.scan_first || dist_w < best_d_r) begin
          best_d_r <= dist_w;
          best_r <= ptr_r;
        end
        if (!stat.scan_last) ptr_r <= ptr_r + IW'(1);
      end
      if (cmd.accum) begin
        res_r.nearest_index <= 4'(best_r);
        if (32'(cnt_r[best_r]) < (32'd1 << PIXELS_LOG2)) begin
          sr_r[best_r] <= (cnt_r[best_r] != '0 ? sr_r[best_r] : '0) + SW'(pr_r);
          sg_r[best_r] <= (cnt_r[best_r] != '0 ? sg_r[best_r] : '0) + SW'(pg_r);
          sb_r[best_r] <= (cnt_r[best_r] != '0 ? sb_r[best_r] : '0) + SW'(pb_r);
          cnt_r[best_r] <= cnt_r[best_r] + NW'(1);
        end
      end
      if (cmd.read_mean) begin
        res_r.nearest_index <= 4'(best_r);
        res_r.out_red <= 16'(valid_r[best_r] ? mean_r[best_r][CHANNEL_BITS-1:0] : '0);
        res_r.out_green <= 16'(valid_r[best_r]
                           ? mean_r[best_r][2*CHANNEL_BITS-1:CHANNEL_BITS] : '0);
        res_r.out_blue <= 16'(valid_r[best_r]
                          ? mean_r[best_r][3*CHANNEL_BITS-1:2*CHANNEL_BITS] : '0);
      end
      if (cmd.div_start) begin
        nr_r <= (cnt_r[ptr_r] != '0) ? sr_r[ptr_r] : '0;
        ng_r <= (cnt_r[ptr_r] != '0) ? sg_r[ptr_r] : '0;
        nb_r <= (cnt_r[ptr_r] != '0) ? sb_r[ptr_r] : '0;
        rr_r <= '0; rg_r <= '0; rb_r <= '0;
        dv_r <= cnt_r[ptr_r];
        bit_r <= BW'(QW);
      end else if (bit_r != '0) begin
        nr_r <= nr_r << 1; ng_r <= ng_r << 1; nb_r <= nb_r << 1;
        rr_r <= tr[NW] ? {rr_r[NW-1:0], nr_r[SW-1]} : tr;
        rg_r <= tg[NW] ? {rg_r[NW-1:0], ng_r[SW-1]} : tg;
        rb_r <= tb[NW] ? {rb_r[NW-1:0], nb_r[SW-1]} : tb;
        qr_r <= {qr_r[QW-2:0], ~tr[NW]};
        qg_r <= {qg_r[QW-2:0], ~tg[NW]};
        qb_r <= {qb_r[QW-2:0], ~tb[NW]};
        bit_r <= bit_r - BW'(1);
      end
      if (cmd.div_write) begin
        valid_r[ptr_r] <= 1'b1;
        if (dv_r == '0) mean_r[ptr_r] <= '0;
        else mean_r[ptr_r] <= {qb_r[CHANNEL_BITS-1:0], qg_r[CHANNEL_BITS-1:0],
                               qr_r[CHANNEL_BITS-1:0]};
        if (!stat.scan_last) ptr_r <= ptr_r + IW'(1);
      end
      if (cmd.clear_all)
        for (int i = 0; i < MAX_MEANS; i++) cnt_r[i] <= '0;
    end
  end
endmodule

// ===== rtl/kmq_ctrl.sv =====
// kmq_ctrl: sequencer for load, scan, accumulate, divide and result handoff
// depends on kmq_pkg
`timescale 1ns / 1ps
module kmq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  kmq_pkg::stat_t stat,
  output kmq_pkg::cmd_t  cmd
);
  import kmq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DISP = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_PICK = 7'b0001000,
    S_DIVS = 7'b0010000,
    S_DIVR = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.func)
          FUNC_LOAD: begin
            cmd.load_mean = 1'b1;
            state_nxt = S_OUT;
          end
          FUNC_END: state_nxt = S_DIVS;
          default: begin
            cmd.scan_first = 1'b1;
            state_nxt = stat.scan_last ? S_PICK : S_SCAN;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = S_PICK;
      end
      S_PICK: begin
        if (stat.func == FUNC_ACCUM) cmd.accum = 1'b1;
        else cmd.read_mean = 1'b1;
        state_nxt = S_OUT;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIVR;
      end
      S_DIVR: begin
        if (stat.div_done) begin
          cmd.div_write = 1'b1;
          if (stat.div_last) begin
            cmd.clear_all = 1'b1;
            state_nxt = S_OUT;
          end else state_nxt = S_DIVS;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_stall) |=> state_r == S_OUT)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> state_r == S_IDLE)
    else $error("request taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_all |-> cmd.div_write)
    else $error("clear without last write");
endmodule

// ===== rtl/kmeans_color_quantizer.sv =====
// kmeans color quantizer: Lloyd k-means for RGB palettes
// load means, accumulate pixels, end a pass, classify pixels; one request, one result.
// after reset all means, sums and counts are zero and num_means is 8.
// accumulate and classify run a sequential distance scan over the mean store;
// end of pass runs the serial divider once for each active mean.
// one request is in flight at a time; in_stall stays high until its result is taken.
// while out_stall is high the result holds on out_item.
// cfg_we writes num_means; write only while idle.
`timescale 1ns / 1ps
module kmeans_color_quantizer #(
  parameter int PIXELS_LOG2  = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kmq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output kmq_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data
);
  import kmq_pkg::*;

  logic [4:0] num_means_r;
  cmd_t cmd;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) num_means_r <= 5'd8;
    else if (cfg_we) num_means_r <= cfg_data;
  end

  kmq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  kmq_datapath #(
    .PIXELS_LOG2(PIXELS_LOG2)
  ) u_dp (
    .clk, .rst_n, .in_item, .num_means(num_means_r), .cmd, .stat, .res(out_item)
  );
endmodule

// ===== dv/kmeans_color_quantizer_tb.sv =====
// kmeans_color_quantizer_tb: self-checking bench for the k-means color quantizer
// predicts every result in-bench and checks it field by field; depends on kmq_pkg and the rtl
`timescale 1ns / 1ps
module kmeans_color_quantizer_tb;
  import kmq_pkg::*;

  localparam int NMEANS = 16;
  localparam longint COUNT_CAP = 64'd1 << 20;
  localparam longint CYCLE_LIMIT = 64'd3_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;

  kmeans_color_quantizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // shadow of the block state
  logic [4:0]  palette_size;
  logic [15:0] pal_r [NMEANS];
  logic [15:0] pal_g [NMEANS];
  logic [15:0] pal_b [NMEANS];
  longint      acc_r [NMEANS];
  longint      acc_g [NMEANS];
  longint      acc_b [NMEANS];
  longint      hits [NMEANS];

  out_item_t   pending_results[$];
  int          mismatches = 0;
  int          checked = 0;
  longint      cycles = 0;
  bit          idle_enable = 1'b1;
  int          func_seen [4];

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result-side stall bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    mismatches++;
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", {12'd0, out_item.nearest_index}, 16'd0);
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (out_item.nearest_index !== want.nearest_index)
          report("nearest_index", {12'd0, out_item.nearest_index}, {12'd0, want.nearest_index});
        if (out_item.out_red !== want.out_red) report("out_red", out_item.out_red, want.out_red);
        if (out_item.out_green !== want.out_green)
          report("out_green", out_item.out_green, want.out_green);
        if (out_item.out_blue !== want.out_blue)
          report("out_blue", out_item.out_blue, want.out_blue);
      end
    end
  end

  function automatic int active_count();
    if (palette_size == 0) return 1;
    if (palette_size > NMEANS) return NMEANS;
    return palette_size;
  endfunction

  function automatic longint sq(input logic [15:0] a, input logic [15:0] b);
    longint d;
    d = (a > b) ? longint'(a - b) : longint'(b - a);
    return d * d;
  endfunction

  function automatic int closest_mean(input in_item_t px);
    int best;
    longint best_d;
    longint d;
    best = 0;
    best_d = 0;
    for (int i = 0; i < active_count(); i++) begin
      d = sq(px.in_red, pal_r[i]) + sq(px.in_green, pal_g[i]) + sq(px.in_blue, pal_b[i]);
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    return best;
  endfunction

  function automatic out_item_t quantize(input in_item_t px);
    out_item_t res;
    int k;
    res = '0;
    case (func_t'(px.func))
      FUNC_LOAD: begin
        pal_r[px.mean_index] = px.in_red;
        pal_g[px.mean_index] = px.in_green;
        pal_b[px.mean_index] = px.in_blue;
      end
      FUNC_ACCUM: begin
        k = closest_mean(px);
        if (hits[k] < COUNT_CAP) begin
          acc_r[k] += px.in_red;
          acc_g[k] += px.in_green;
          acc_b[k] += px.in_blue;
          hits[k] += 1;
        end
        res.nearest_index = k[3:0];
      end
      FUNC_END: begin
        for (int i = 0; i < active_count(); i++) begin
          if (hits[i] != 0) begin
            pal_r[i] = 16'(acc_r[i] / hits[i]);
            pal_g[i] = 16'(acc_g[i] / hits[i]);
            pal_b[i] = 16'(acc_b[i] / hits[i]);
          end else begin
            pal_r[i] = '0;
            pal_g[i] = '0;
            pal_b[i] = '0;
          end
        end
        for (int i = 0; i < NMEANS; i++) begin
          acc_r[i] = 0;
          acc_g[i] = 0;
          acc_b[i] = 0;
          hits[i] = 0;
        end
      end
      default: begin
        k = closest_mean(px);
        res.nearest_index = k[3:0];
        res.out_red = pal_r[k];
        res.out_green = pal_g[k];
        res.out_blue = pal_b[k];
      end
    endcase
    return res;
  endfunction

  task automatic send_request(input in_item_t req);
    int n;
    @(posedge clk);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 16);
      repeat (n) @(posedge clk);
    end
    in_item <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(quantize(req));
    func_seen[req.func]++;
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_palette_size(input logic [4:0] v);
    wait_drained();
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    palette_size = v;
  endtask

  function automatic in_item_t make_req(input func_t f, input logic [3:0] idx,
                                        input logic [15:0] r, input logic [15:0] g,
                                        input logic [15:0] b);
    in_item_t t;
    t.func = f;
    t.mean_index = idx;
    t.in_red = r;
    t.in_green = g;
    t.in_blue = b;
    return t;
  endfunction

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_req(input int p_load, input int p_end);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < p_load)
      return make_req(FUNC_LOAD, 4'($urandom), rand_chan(), rand_chan(), rand_chan());
    if (roll < p_load + p_end)
      return make_req(FUNC_END, 4'($urandom), rand_chan(), rand_chan(), rand_chan());
    return make_req(roll[0] ? FUNC_ACCUM : FUNC_CLASS, 4'($urandom),
                    rand_chan(), rand_chan(), rand_chan());
  endfunction

  task automatic test_directed();
    send_request(make_req(FUNC_CLASS, 4'd0, 16'h1234, 16'h5678, 16'h9abc));
    send_request(make_req(FUNC_LOAD, 4'd0, 16'h0000, 16'h0000, 16'h0000));
    send_request(make_req(FUNC_LOAD, 4'd1, 16'hffff, 16'hffff, 16'hffff));
    send_request(make_req(FUNC_LOAD, 4'd2, 16'h8000, 16'h8000, 16'h8000));
    send_request(make_req(FUNC_LOAD, 4'd15, 16'h0001, 16'h0001, 16'h0001));
    // tie goes to the lower index
    send_request(make_req(FUNC_LOAD, 4'd3, 16'h8000, 16'h8000, 16'h8000));
    send_request(make_req(FUNC_CLASS, 4'd0, 16'h8000, 16'h8000, 16'h8000));
    send_request(make_req(FUNC_ACCUM, 4'd0, 16'hffff, 16'hffff, 16'hffff));
    send_request(make_req(FUNC_ACCUM, 4'd0, 16'hfffe, 16'hffff, 16'hfff0));
    send_request(make_req(FUNC_ACCUM, 4'd0, 16'h0000, 16'h0010, 16'h0000));
    send_request(make_req(FUNC_ACCUM, 4'd0, 16'h7000, 16'h9000, 16'h8000));
    send_request(make_req(FUNC_END, 4'd0, 16'h0000, 16'h0000, 16'h0000));
    send_request(make_req(FUNC_CLASS, 4'd0, 16'hffff, 16'h0000, 16'hffff));
    send_request(make_req(FUNC_CLASS, 4'd0, 16'h0000, 16'hffff, 16'h0000));
    // a mean above the palette size is stored but unused
    send_request(make_req(FUNC_LOAD, 4'd12, 16'h4321, 16'h4321, 16'h4321));
    send_request(make_req(FUNC_CLASS, 4'd0, 16'h4321, 16'h4321, 16'h4321));
    send_request(make_req(FUNC_END, 4'd0, 16'hffff, 16'hffff, 16'hffff));
  endtask

  task automatic test_palette_sizes();
    logic [4:0] sizes [6];
    sizes = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd3};
    foreach (sizes[s]) begin
      write_palette_size(sizes[s]);
      for (int i = 0; i < 16; i++)
        send_request(make_req(FUNC_LOAD, 4'(i), rand_chan(), rand_chan(), rand_chan()));
      repeat (8) send_request(rand_req(0, 0));
      send_request(make_req(FUNC_END, 4'd0, 16'd0, 16'd0, 16'd0));
      repeat (4) send_request(make_req(FUNC_CLASS, 4'd0, rand_chan(), rand_chan(), rand_chan()));
    end
  endtask

  // host-style passes: sometimes load palette, stream pixels, close, classify
  task automatic test_lloyd_passes(input int passes);
    for (int p = 0; p < passes; p++) begin
      if (p % 6 == 0) write_palette_size(5'($urandom_range(1, 16)));
      if ($urandom_range(0, 2) == 0)
        for (int i = 0; i < active_count(); i++)
          send_request(make_req(FUNC_LOAD, 4'(i), rand_chan(), rand_chan(), rand_chan()));
      repeat ($urandom_range(10, 30)) send_request(rand_req(3, 0));
      send_request(make_req(FUNC_END, 4'($urandom), rand_chan(), rand_chan(), rand_chan()));
      repeat ($urandom_range(3, 8)) send_request(rand_req(0, 0));
      if (p == passes / 2) wait_drained();
    end
  endtask

  task automatic test_noise(input int n);
    repeat (n) send_request(rand_req(15, 10));
  endtask

  initial begin
    palette_size = 5'd8;
    for (int i = 0; i < NMEANS; i++) begin
      pal_r[i] = '0; pal_g[i] = '0; pal_b[i] = '0;
      acc_r[i] = 0; acc_g[i] = 0; acc_b[i] = 0; hits[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_palette_sizes();
    test_lloyd_passes(12);
    test_noise(120);
    idle_enable = 1'b0;
    test_lloyd_passes(3);
    wait_drained();
    $display("covered %0d loads, %0d accumulates, %0d pass ends, %0d classifies",
             func_seen[0], func_seen[1], func_seen[2], func_seen[3]);
    $display("%0d results checked, %0d mismatches, palette sizes 0..31 exercised",
             checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
